[sv/sliding_window_flood_limiter_defines.svh]
// Assertion macros shared by the flood limiter checker.
// Depends on nothing; the including scope must provide i_clk and i_rst_n.
`ifndef SLIDING_WINDOW_FLOOD_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_FLOOD_LIMITER_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define SWFL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("flood limiter check failed");

// Next-cycle implication, checked only while out of reset.
`define SWFL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("flood limiter check failed");

`endif

[sv/swfl_pkg.sv]
// Shared constants, codes and types of the sliding-window flood limiter.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package swfl_pkg;

    // Default number of window entries (legal range 1 to 63).
    localparam int WINDOW_DEPTH_DEF = 31;

    // Field widths.
    localparam int ID_W    = 32;
    localparam int TIME_W  = 32;
    localparam int CNT_CFG_W = 6;
    localparam int SPAN_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int VERDICT_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 2'd3;

    // Configuration reset values.
    localparam logic [CNT_CFG_W-1:0] RST_MAX_RUN   = 6'd10;
    localparam logic [CNT_CFG_W-1:0] RST_MAX_TOTAL = 6'd15;
    localparam logic [SPAN_W-1:0]    RST_SPAN      = 16'd45;
    localparam logic [SPAN_W-1:0]    RST_MIN_GAP   = 16'd1;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] V_NORMAL = 2'd0;
    localparam logic [VERDICT_W-1:0] V_RUN    = 2'd1;
    localparam logic [VERDICT_W-1:0] V_SOON   = 2'd2;
    localparam logic [VERDICT_W-1:0] V_MANY   = 2'd3;

    // Port enables from the sequencer to the window memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_win_cmd;

endpackage

[sv/swfl_age_cmp.sv]
// Shared age unit: modular age of a stamp and compare against a limit.
// Depends on swfl_pkg for the field widths.
`timescale 1ns / 1ps

module swfl_age_cmp (
    input  logic [swfl_pkg::TIME_W-1:0] i_now,
    input  logic [swfl_pkg::TIME_W-1:0] i_stamp,
    input  logic [swfl_pkg::SPAN_W-1:0] i_limit,
    output logic                        o_below
);
    import swfl_pkg::*;

    logic [TIME_W-1:0] age;

    // Age wraps modulo 2^32, so time going backward reads as very old.
    assign age     = i_now - i_stamp;
    assign o_below = age < {{(TIME_W-SPAN_W){1'b0}}, i_limit};

endmodule

[sv/swfl_window.sv]
// Window store: circular buffer of (sender, time) entries.
// One write port and one registered read port. Depends on swfl_pkg.
`timescale 1ns / 1ps

module swfl_window #(
    parameter int DEPTH = swfl_pkg::WINDOW_DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  swfl_pkg::t_win_cmd          i_cmd,
    input  logic [IDX_W-1:0]            i_wr_addr,
    input  logic [swfl_pkg::ID_W-1:0]   i_wr_sender,
    input  logic [swfl_pkg::TIME_W-1:0] i_wr_time,
    input  logic [IDX_W-1:0]            i_rd_addr,
    output logic [swfl_pkg::ID_W-1:0]   o_rd_sender,
    output logic [swfl_pkg::TIME_W-1:0] o_rd_time
);
    import swfl_pkg::*;

    logic [ID_W+TIME_W-1:0] r_mem [DEPTH];
    logic [ID_W+TIME_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_sender, i_wr_time};
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_sender = r_rd_data[ID_W+TIME_W-1:TIME_W];
    assign o_rd_time   = r_rd_data[TIME_W-1:0];

endmodule

[sv/sliding_window_flood_limiter.sv]
// Top level of the sliding-window flood limiter: config registers, scan sequencer,
// result register. Depends on swfl_pkg, swfl_window and swfl_age_cmp.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_sender_id, i_now_seconds, i_tracked
//   result    out        o_out_valid / i_out_ready  o_verdict
//   config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// A tracked beat scans the window newest first, one entry per cycle through the single
// read port and the shared age unit, then goes to the span check, then the result load.
// A run or too-soon hit ends the scan early. An untracked beat goes straight to the
// result load. The block is ready again once the result is loaded, so it takes no new
// beat until the last one's result is loaded; a stalled result only holds the next item
// in its last step. Reset is synchronous and active low.
`timescale 1ns / 1ps

module sliding_window_flood_limiter #(
    parameter int WINDOW_DEPTH = swfl_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [swfl_pkg::ID_W-1:0]       i_sender_id,
    input  logic [swfl_pkg::TIME_W-1:0]     i_now_seconds,
    input  logic                            i_tracked,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [swfl_pkg::VERDICT_W-1:0]  o_verdict,
    input  logic                            i_cfg_we,
    input  logic [swfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swfl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import swfl_pkg::*;

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_FILL = CNT_W'(WINDOW_DEPTH);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Control registers.
    logic [1:0]           r_state, n_state;
    logic [IDX_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic                 r_out_valid, n_out_valid;
    logic [CNT_CFG_W-1:0] r_max_run, r_max_total;
    logic [SPAN_W-1:0]    r_span, r_min_gap;

    // Per-item working registers.
    logic [ID_W-1:0]      r_who, n_who;
    logic [TIME_W-1:0]    r_now, n_now;
    logic [TIME_W-1:0]    r_oldest, n_oldest;
    logic [IDX_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [CNT_W-1:0]     r_run, n_run;
    logic [CNT_W-1:0]     r_total, n_total;
    logic                 r_run_open, n_run_open;
    logic [VERDICT_W-1:0] r_res, n_res;
    logic [VERDICT_W-1:0] r_verdict, n_verdict;

    // Datapath wires.
    t_win_cmd          win_cmd;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  head_next;
    logic [ID_W-1:0]   rd_sender;
    logic [TIME_W-1:0] rd_time;
    logic [TIME_W-1:0] age_stamp;
    logic [SPAN_W-1:0] age_limit;
    logic              age_below;
    logic [CNT_W-1:0]  run_inc;
    logic [CNT_W-1:0]  k_inc;
    logic              match;

    function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] idx);
        prev_idx = (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    function automatic logic [CNT_CFG_W-1:0] widen(input logic [CNT_W-1:0] cnt);
        widen = {{(CNT_CFG_W-CNT_W){1'b0}}, cnt};
    endfunction

    // Window memory and shared age unit.
    swfl_window #(
        .DEPTH(WINDOW_DEPTH)
    ) u_window (
        .i_clk      (i_clk),
        .i_cmd      (win_cmd),
        .i_wr_addr  (head_next),
        .i_wr_sender(r_who),
        .i_wr_time  (r_now),
        .i_rd_addr  (rd_addr),
        .o_rd_sender(rd_sender),
        .o_rd_time  (rd_time)
    );

    swfl_age_cmp u_age (
        .i_now  (r_now),
        .i_stamp(age_stamp),
        .i_limit(age_limit),
        .o_below(age_below)
    );

    // The age unit checks the minimum gap while scanning and the span at the end.
    assign age_stamp = (r_state == ST_FINAL) ? r_oldest : rd_time;
    assign age_limit = (r_state == ST_FINAL) ? r_span : r_min_gap;

    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign run_inc   = r_run + 1'b1;
    assign k_inc     = r_k + 1'b1;
    assign match     = (rd_sender == r_who);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        n_who       = r_who;
        n_now       = r_now;
        n_oldest    = r_oldest;
        n_rd_ptr    = r_rd_ptr;
        n_k         = r_k;
        n_run       = r_run;
        n_total     = r_total;
        n_run_open  = r_run_open;
        n_res       = r_res;
        n_verdict   = r_verdict;
        win_cmd     = '0;
        rd_addr     = r_rd_ptr;

        // A taken result frees the output register.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_who      = i_sender_id;
                    n_now      = i_now_seconds;
                    n_oldest   = i_now_seconds;
                    n_run      = '0;
                    n_total    = '0;
                    n_k        = '0;
                    n_run_open = 1'b1;
                    if (!i_tracked) begin
                        n_res   = V_NORMAL;
                        n_state = ST_DONE;
                    end else if (r_fill == '0) begin
                        n_state = ST_FINAL;
                    end else begin
                        // Start reading at the newest entry.
                        win_cmd.rd_en = 1'b1;
                        rd_addr       = r_head;
                        n_rd_ptr      = prev_idx(r_head);
                        n_state       = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Check entry r_k while the next older one is being read.
                win_cmd.rd_en = 1'b1;
                rd_addr       = r_rd_ptr;
                n_rd_ptr      = prev_idx(r_rd_ptr);
                n_k           = k_inc;
                if (k_inc == r_fill) begin
                    n_state = ST_FINAL;
                end
                if (!match) begin
                    n_run_open = 1'b0;
                end else if (r_run_open && (widen(run_inc) >= r_max_run)) begin
                    n_res   = V_RUN;
                    n_state = ST_DONE;
                end else if (age_below) begin
                    n_res   = V_SOON;
                    n_state = ST_DONE;
                end else begin
                    if (r_run_open) begin
                        n_run = run_inc;
                    end
                    n_total  = r_total + 1'b1;
                    n_oldest = rd_time;
                end
            end
            ST_FINAL: begin
                n_state = ST_DONE;
                if ((widen(r_total) >= r_max_total) && age_below) begin
                    n_res = V_MANY;
                end else begin
                    // Passed: record at the new head, overwriting the oldest when full.
                    n_res         = V_NORMAL;
                    win_cmd.wr_en = 1'b1;
                    n_head        = head_next;
                    if (r_fill != FULL_FILL) begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_verdict   = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_max_run   <= RST_MAX_RUN;
            r_max_total <= RST_MAX_TOTAL;
            r_span      <= RST_SPAN;
            r_min_gap   <= RST_MIN_GAP;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_RUN:   r_max_run   <= i_cfg_data[CNT_CFG_W-1:0];
                    CFG_MAX_TOTAL: r_max_total <= i_cfg_data[CNT_CFG_W-1:0];
                    CFG_SPAN:      r_span      <= i_cfg_data[SPAN_W-1:0];
                    CFG_MIN_GAP:   r_min_gap   <= i_cfg_data[SPAN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_who      <= n_who;
        r_now      <= n_now;
        r_oldest   <= n_oldest;
        r_rd_ptr   <= n_rd_ptr;
        r_k        <= n_k;
        r_run      <= n_run;
        r_total    <= n_total;
        r_run_open <= n_run_open;
        r_res      <= n_res;
        r_verdict  <= n_verdict;
    end

endmodule

[sv/swfl_checker.sv]
// Port-level checker for the sliding-window flood limiter, with its bind.
// Depends on swfl_pkg and sliding_window_flood_limiter_defines.svh.
`timescale 1ns / 1ps
`include "sliding_window_flood_limiter_defines.svh"

module swfl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [swfl_pkg::VERDICT_W-1:0] o_verdict
);
    import swfl_pkg::*;

    // No result is pending right after reset.
    `SWFL_ASSERT_NOW(a_no_result_after_reset, $past(!i_rst_n), !o_out_valid)

    // An accepted beat keeps the block busy for at least the next cycle.
    `SWFL_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // A new result only appears once the block has returned to idle.
    `SWFL_ASSERT_NOW(a_result_when_idle, $rose(o_out_valid), o_in_ready)

    // A stalled result holds its verdict.
    `SWFL_ASSERT_NEXT(a_result_holds, o_out_valid && !i_out_ready,
                      o_out_valid && $stable(o_verdict))

endmodule

bind sliding_window_flood_limiter swfl_checker u_swfl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_verdict  (o_verdict)
);

[dv/sliding_window_flood_limiter_tb.sv]
// Self-checking testbench for the sliding-window flood limiter: directed and random
// requests, checked verdict by verdict against a predictor. Depends on swfl_pkg and
// sliding_window_flood_limiter.
`timescale 1ns / 1ps

module sliding_window_flood_limiter_tb;

    import swfl_pkg::*;

    localparam int WIN_DEPTH       = WINDOW_DEPTH_DEF;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int SETTLE_CYCLES   = WIN_DEPTH + 8;
    localparam int CYCLE_LIMIT     = 1000000;

    // Scoreboard: keeps its own copy of the limits and the window, predicts the
    // verdict of every accepted request and checks the verdicts in order.
    class verdict_board;
        logic [CNT_CFG_W-1:0] run_limit;
        logic [CNT_CFG_W-1:0] total_limit;
        logic [SPAN_W-1:0]    span_limit;
        logic [SPAN_W-1:0]    gap_limit;
        logic [ID_W-1:0]      win_who [WIN_DEPTH];
        logic [TIME_W-1:0]    win_at [WIN_DEPTH];
        int unsigned          win_fill;
        logic [VERDICT_W-1:0] pending_verdicts [$];
        int unsigned          requests;
        int unsigned          checked;
        int unsigned          mismatches;
        int unsigned          verdict_seen [4];

        function new();
            run_limit   = RST_MAX_RUN;
            total_limit = RST_MAX_TOTAL;
            span_limit  = RST_SPAN;
            gap_limit   = RST_MIN_GAP;
            win_fill    = 0;
            requests    = 0;
            checked     = 0;
            mismatches  = 0;
            foreach (verdict_seen[v]) verdict_seen[v] = 0;
        endfunction

        // Mirror one register write; data is cut to the register width.
        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAX_RUN:   run_limit   = data[CNT_CFG_W-1:0];
                CFG_MAX_TOTAL: total_limit = data[CNT_CFG_W-1:0];
                CFG_SPAN:      span_limit  = data[SPAN_W-1:0];
                CFG_MIN_GAP:   gap_limit   = data[SPAN_W-1:0];
                default: ;
            endcase
        endfunction

        // Scan the window newest first: head run, then too soon, then the total.
        function logic [VERDICT_W-1:0] predict_verdict(logic [ID_W-1:0] who,
                                                       logic [TIME_W-1:0] now);
            int unsigned       run;
            int unsigned       total;
            bit                run_open;
            logic [TIME_W-1:0] oldest;
            logic [TIME_W-1:0] age;
            run      = 0;
            total    = 0;
            run_open = 1'b1;
            oldest   = now;
            for (int k = 0; k < win_fill; k++) begin
                if (win_who[k] != who) begin
                    run_open = 1'b0;
                end else begin
                    if (run_open) begin
                        run++;
                        if (run >= run_limit) return V_RUN;
                    end
                    age = now - win_at[k];
                    if (age < gap_limit) return V_SOON;
                    total++;
                    oldest = win_at[k];
                end
            end
            age = now - oldest;
            if (total >= total_limit && age < span_limit) return V_MANY;
            return V_NORMAL;
        endfunction

        // An accepted request: predict its verdict and record it if it passes.
        function void note_request(logic [ID_W-1:0] who, logic [TIME_W-1:0] now,
                                   logic tracked);
            logic [VERDICT_W-1:0] verdict;
            verdict = tracked ? predict_verdict(who, now) : V_NORMAL;
            if (tracked && verdict == V_NORMAL) begin
                for (int k = WIN_DEPTH - 1; k > 0; k--) begin
                    win_who[k] = win_who[k-1];
                    win_at[k]  = win_at[k-1];
                end
                win_who[0] = who;
                win_at[0]  = now;
                if (win_fill < WIN_DEPTH) win_fill++;
            end
            pending_verdicts.push_back(verdict);
            requests++;
        endfunction

        // A verdict beat from the block: compare with the oldest prediction.
        function void check_verdict(logic [VERDICT_W-1:0] actual);
            logic [VERDICT_W-1:0] expected;
            checked++;
            verdict_seen[actual]++;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected verdict, expected none, actual %0d",
                         $time, actual);
            end else begin
                expected = pending_verdicts.pop_front();
                if (expected !== actual) begin
                    mismatches++;
                    $display("%0t: verdict mismatch, expected %0d, actual %0d",
                             $time, expected, actual);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [ID_W-1:0]       i_sender_id;
    logic [TIME_W-1:0]     i_now_seconds;
    logic                  i_tracked;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [VERDICT_W-1:0]  o_verdict;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    verdict_board board;
    int unsigned  send_idle_pct;
    int unsigned  stall_pct;
    int unsigned  hold_request;
    int unsigned  cycle_count;
    int unsigned  settings_used;

    sliding_window_flood_limiter #(
        .WINDOW_DEPTH(WIN_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sender_id  (i_sender_id),
        .i_now_seconds(i_now_seconds),
        .i_tracked    (i_tracked),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_verdict    (o_verdict),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side ready: random stalls, or a long hold-off counted down here.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Verdict monitor and run timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && i_out_ready) board.check_verdict(o_verdict);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One request beat; valid stays high afterwards until the next call decides.
    task automatic send_request(input logic [ID_W-1:0] who, input logic [TIME_W-1:0] now,
                                input logic tracked);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_sender_id   = who;
        i_now_seconds = now;
        i_tracked     = tracked;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(who, now, tracked);
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every predicted verdict, then let the block settle.
    task automatic await_verdicts();
        i_in_valid = 1'b0;
        while (board.pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        board.note_config(idx, data);
        @(negedge i_clk);
    endtask

    // Write all four limits back to back while the block is idle.
    task automatic set_limits(input logic [CFG_DATA_W-1:0] run, input logic [CFG_DATA_W-1:0] total,
                              input logic [CFG_DATA_W-1:0] span, input logic [CFG_DATA_W-1:0] gap);
        write_reg(CFG_MAX_RUN, run);
        write_reg(CFG_MAX_TOTAL, total);
        write_reg(CFG_SPAN, span);
        write_reg(CFG_MIN_GAP, gap);
        i_cfg_we = 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [ID_W-1:0]   pool [4];
        logic [TIME_W-1:0] clock_now;
        int unsigned       pick;
        int unsigned       roll;
        board         = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 0;
        cycle_count   = 0;
        settings_used = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_sender_id   = '0;
        i_now_seconds = '0;
        i_tracked     = 1'b0;
        i_out_ready   = 1'b1;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_MAX_RUN;
        i_cfg_data    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset limits, untracked pass, too soon, time running backward.
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_request(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_request(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(32'h0000_0000, 32'hFFFF_FFF0, 1'b1);
        send_request(32'hAAAA_5555, 32'h5555_AAAA, 1'b1);

        // Zero run limit: any head entry of the sender flags a run.
        await_verdicts();
        set_limits(16'd0, 16'd15, 16'd45, 16'd1);
        send_request(32'hAAAA_5555, 32'h5555_AAB0, 1'b1);
        send_request(32'h1234_5678, 32'h5555_AAB1, 1'b1);

        // Zero total limit with no entries of the sender, with and without a span.
        await_verdicts();
        set_limits(16'd63, 16'd0, 16'hFFFF, 16'd0);
        send_request(32'hCAFE_0000, 32'd100, 1'b1);
        await_verdicts();
        set_limits(16'd63, 16'd0, 16'd0, 16'd0);
        send_request(32'hCAFE_0000, 32'd100, 1'b1);

        // Widest gap: any earlier entry of the sender is too recent.
        await_verdicts();
        set_limits(16'd63, 16'd63, 16'hFFFF, 16'hFFFF);
        send_request(32'hCAFE_0000, 32'd200, 1'b1);

        // Short run and total limits; upper data bits must be dropped.
        await_verdicts();
        set_limits(16'hFFC3, 16'h0402, 16'd100, 16'd0);
        send_request(32'h0F0F_0F0F, 32'd1000, 1'b1);
        send_request(32'h0F0F_0F0F, 32'd1000, 1'b1);
        send_request(32'h0F0F_0F0F, 32'd1001, 1'b1);
        send_request(32'h1111_1111, 32'd1003, 1'b1);
        send_request(32'h0F0F_0F0F, 32'd5000, 1'b1);
        send_request(32'h0F0F_0F0F, 32'd5001, 1'b1);
        send_request(32'h0F0F_0F0F, 32'd5002, 1'b1);
        send_request(32'h0F0F_0F0F, 32'd5003, 1'b1);

        // Random phases, each with its own limits and idling pattern.
        for (int p = 0; p < PHASES; p++) begin
            await_verdicts();
            case (p)
                0: set_limits(16'd10, 16'd15, 16'd45, 16'd1);
                1: set_limits(16'd1, 16'd1, 16'd0, 16'd0);
                2: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: set_limits(16'hFFC0, 16'hFFC0, 16'd0, 16'd0);
                default: set_limits({10'($urandom), 6'($urandom_range(1, 8))},
                                    {10'($urandom), 6'($urandom_range(1, 12))},
                                    16'($urandom_range(0, 40)),
                                    16'($urandom_range(0, 3)));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            pool[0]   = 32'($urandom);
            pool[1]   = 32'h0000_0000;
            pool[2]   = 32'hFFFF_FFFF;
            pool[3]   = 32'($urandom);
            clock_now = (p % 2 == 1) ? 32'hFFFF_FFC0 : 32'($urandom);
            pick      = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Long result hold-off while requests keep coming.
                if (p % 4 == 0 && n == 60) hold_request = 300;
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    send_request(32'($urandom), 32'($urandom), 1'($urandom));
                end else begin
                    if ($urandom_range(0, 99) >= 60) pick = $urandom_range(0, 3);
                    roll = $urandom_range(0, 99);
                    if (roll < 85)
                        clock_now = clock_now + 32'($urandom_range(0, 2));
                    else if (roll < 95)
                        clock_now = clock_now + 32'($urandom_range(3, 60));
                    else
                        clock_now = clock_now - 32'($urandom_range(1, 5));
                    send_request(pool[pick], clock_now, $urandom_range(0, 99) >= 9);
                end
            end
        end

        await_verdicts();
        $display("Ran %0d requests under %0d limit settings; %0d verdicts checked.",
                 board.requests, settings_used, board.checked);
        $display("Verdict mix: normal %0d, run %0d, too soon %0d, too many %0d.",
                 board.verdict_seen[0], board.verdict_seen[1],
                 board.verdict_seen[2], board.verdict_seen[3]);
        if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
